// ----- sv/fst_pkg.sv -----
// shared constants, codes and types of the fade slot table
package fst_pkg;

  localparam int SLOTS  = 3;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam int TYPE_W = 8;
  localparam int ANG_W  = 16;
  localparam int DIST_W = 16;
  localparam int DUR_W  = 16;
  localparam int OP_W   = 16;
  localparam int TICK_W = 10;
  localparam int DEAD_W = 8;
  localparam int NUM_W  = TICK_W + OP_W;

  localparam logic [OP_W-1:0]   OPAQUE    = '1;
  localparam logic [OP_W-1:0]   NEAR_ZERO = OP_W'(655);
  localparam logic [DEAD_W-1:0] DEAD_MAX  = '1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_DURATION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TICK_MS          = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CLEANUP_TICKS    = CFG_IDX_W'(2);

  localparam logic [DUR_W-1:0]  DEFAULT_DURATION_RST = DUR_W'(200);
  localparam logic [TICK_W-1:0] TICK_MS_RST          = TICK_W'(50);
  localparam logic [DEAD_W-1:0] CLEANUP_TICKS_RST    = DEAD_W'(2);

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_SHOW  = 2'd1,
    FUNC_HIDE  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef struct packed {
    func_t                    func;
    logic [TYPE_W-1:0]        prop_type;
    logic signed [ANG_W-1:0]  angle;
    logic [DIST_W-1:0]        distance;
    logic [DUR_W-1:0]         fade_ms;
  } item_t;

  typedef struct packed {
    logic                     slot_present;
    logic [TYPE_W-1:0]        prop_type_res;
    logic signed [ANG_W-1:0]  angle_res;
    logic [DIST_W-1:0]        distance_res;
    logic [OP_W-1:0]          opacity;
    logic                     last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             div_start;
    logic             walk;
    logic             finish;
    logic             emit;
    logic [IDX_W-1:0] idx;
  } fst_cmd_t;

  // datapath to controller
  typedef struct packed {
    func_t            func;
    logic             div_done;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } fst_sts_t;

endpackage

// ----- sv/fst_if.sv -----
// valid/ready channel interfaces for items and results
interface fst_item_if;
  import fst_pkg::*;
  logic  valid;
  logic  ready;
  item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fst_result_if;
  import fst_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/fade_slot_table_unit.sv -----
// top level of the fade slot table: controller, datapath and channel wiring
// a tick item goes straight to the slot walk (one walk cycle per live slot);
// show, hide and clear first run the bit-serial fade step divide
// (one quotient bit per cycle, 26 bits)
// items are taken one at a time, and the result side can hold the flow with ready low;
// 3 result beats per item
// reset: synchronous, clears the table to empty and config to 200 ms, 50 ms, 2 ticks
module fade_slot_table_unit (
  input  logic                           clk,
  input  logic                           rst,
  fst_item_if.sink                       item,
  fst_result_if.source                   result,
  input  logic                           wr_en,
  input  logic [fst_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [fst_pkg::CFG_DATA_W-1:0] wr_data
);
  import fst_pkg::*;

  fst_cmd_t cmd;
  fst_sts_t sts;
  logic     item_ready;
  logic     result_valid;
  result_t  result_payload;

  // controller: one item at a time, idle -> dispatch -> divide (not for tick) -> slot walk -> update -> 3 beats
  fst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: slot table in flops, one slot touched per cycle
  // tick updates opacity/dead count and compacts in the same pass
  // the result register decouples the output side, so a new item can be
  // taken while the last beat of the previous one still waits
  fst_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_payload  (item.payload),
    .out_valid   (result_valid),
    .out_ready   (result.ready),
    .out_payload (result_payload),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data)
  );

  // input beat accepted only while the controller is idle
  assign item.ready     = item_ready;
  assign result.valid   = result_valid;
  assign result.payload = result_payload;

endmodule

// ----- sv/fst_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module fst_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fst_pkg::NUM_W-1:0]   num,
  input  logic [fst_pkg::DUR_W-1:0]   den,
  output logic                        done,
  output logic [fst_pkg::NUM_W-1:0]   quot
);
  import fst_pkg::*;

  localparam int BIT_CNT_W = $clog2(NUM_W);

  logic                 busy;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [DUR_W-1:0]     rem;
  logic [DUR_W:0]       trial;
  logic                 fits;

  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy    <= 1'b1;
      done    <= 1'b0;
      bit_cnt <= BIT_CNT_W'(NUM_W - 1);
      rem     <= '0;
      quot    <= num;
    end else if (busy) begin
      rem  <= fits ? DUR_W'(trial - {1'b0, den}) : trial[DUR_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
      if (bit_cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        bit_cnt <= bit_cnt - 1'b1;
      end
    end
  end

endmodule

// ----- sv/fst_dp.sv -----
// datapath: config registers, slot table, fade step divider, result register
module fst_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  fst_pkg::fst_cmd_t              cmd,
  output fst_pkg::fst_sts_t              sts,
  input  fst_pkg::item_t                 in_payload,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fst_pkg::result_t               out_payload,
  input  logic                           wr_en,
  input  logic [fst_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [fst_pkg::CFG_DATA_W-1:0] wr_data
);
  import fst_pkg::*;

  typedef struct packed {
    logic [TYPE_W-1:0]       prop_type;
    logic signed [ANG_W-1:0] angle;
    logic [DIST_W-1:0]       distance;
    logic [OP_W-1:0]         opacity;
    logic                    target_full;
    logic [OP_W-1:0]         step;
    logic [DEAD_W-1:0]       dead;
  } slot_t;

  logic [DUR_W-1:0]  default_duration;
  logic [TICK_W-1:0] tick_ms;
  logic [DEAD_W-1:0] cleanup_ticks;

  item_t             item;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  wr_ptr;
  logic              found;
  slot_t             slots [SLOTS];

  logic              div_done;
  logic [NUM_W-1:0]  quot;
  logic [NUM_W-1:0]  num;
  logic [DUR_W-1:0]  den;
  logic [OP_W-1:0]   new_step;

  slot_t             rd;
  logic [OP_W-1:0]   gap;
  logic [OP_W-1:0]   op_next;
  logic [DEAD_W-1:0] dead_next;
  logic              keep;
  logic              type_hit;
  logic              append;

  logic              slot_we;
  logic [IDX_W-1:0]  slot_addr;
  slot_t             slot_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_duration <= DEFAULT_DURATION_RST;
      tick_ms          <= TICK_MS_RST;
      cleanup_ticks    <= CLEANUP_TICKS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEFAULT_DURATION: default_duration <= wr_data;
        REG_TICK_MS:          tick_ms          <= wr_data[TICK_W-1:0];
        REG_CLEANUP_TICKS:    cleanup_ticks    <= wr_data[DEAD_W-1:0];
        default: ;
      endcase
    end
  end

  // step = tick_ms * 65535 / duration, saturated
  assign num = NUM_W'({tick_ms, {OP_W{1'b0}}}) - NUM_W'(tick_ms);
  always_comb begin
    den = item.fade_ms;
    if (den == '0) den = default_duration;
    if (den == '0) den = DUR_W'(1);
  end
  assign new_step = (quot[NUM_W-1:OP_W] != '0) ? OPAQUE : quot[OP_W-1:0];

  fst_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  // one slot per cycle at the walk index
  assign rd       = slots[cmd.idx];
  assign gap      = rd.target_full ? (OPAQUE - rd.opacity) : rd.opacity;
  assign type_hit = !found && (rd.prop_type == item.prop_type);
  assign append   = (item.func == FUNC_SHOW) && !found && (count < CNT_W'(SLOTS));

  always_comb begin
    if (gap <= rd.step) op_next = rd.target_full ? OPAQUE : '0;
    else                op_next = rd.target_full ? rd.opacity + rd.step
                                                 : rd.opacity - rd.step;
    if (!rd.target_full && op_next <= NEAR_ZERO)
      dead_next = (rd.dead == DEAD_MAX) ? rd.dead : rd.dead + 1'b1;
    else
      dead_next = '0;
    keep = dead_next < cleanup_ticks;
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_addr  = cmd.idx;
    slot_wdata = rd;
    if (cmd.walk) begin
      unique case (item.func)
        FUNC_TICK: begin
          slot_we            = keep;
          slot_addr          = IDX_W'(wr_ptr);
          slot_wdata.opacity = op_next;
          slot_wdata.dead    = dead_next;
        end
        FUNC_SHOW: begin
          slot_we                = type_hit;
          slot_wdata.target_full = 1'b1;
          slot_wdata.step        = new_step;
          slot_wdata.angle       = item.angle;
          slot_wdata.distance    = item.distance;
        end
        FUNC_HIDE: begin
          slot_we                = type_hit;
          slot_wdata.target_full = 1'b0;
          slot_wdata.step        = new_step;
        end
        FUNC_CLEAR: begin
          slot_we                = 1'b1;
          slot_wdata.target_full = 1'b0;
          slot_wdata.step        = new_step;
        end
        default: ;
      endcase
    end else if (cmd.finish && append) begin
      slot_we                = 1'b1;
      slot_addr              = IDX_W'(count);
      slot_wdata.prop_type   = item.prop_type;
      slot_wdata.angle       = item.angle;
      slot_wdata.distance    = item.distance;
      slot_wdata.opacity     = '0;
      slot_wdata.target_full = 1'b1;
      slot_wdata.step        = new_step;
      slot_wdata.dead        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) slots[slot_addr] <= slot_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      found  <= 1'b0;
    end else begin
      if (cmd.load) begin
        wr_ptr <= '0;
        found  <= 1'b0;
      end
      if (cmd.walk) begin
        if (item.func == FUNC_TICK && keep) wr_ptr <= wr_ptr + 1'b1;
        if ((item.func == FUNC_SHOW || item.func == FUNC_HIDE) && type_hit) found <= 1'b1;
      end
      if (cmd.finish) begin
        if (item.func == FUNC_TICK) count <= wr_ptr;
        else if (append)            count <= count + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (CNT_W'(cmd.idx) < count) begin
        out_payload.slot_present  <= 1'b1;
        out_payload.prop_type_res <= rd.prop_type;
        out_payload.angle_res     <= rd.angle;
        out_payload.distance_res  <= rd.distance;
        out_payload.opacity       <= rd.opacity;
      end else begin
        out_payload.slot_present  <= 1'b0;
        out_payload.prop_type_res <= '0;
        out_payload.angle_res     <= '0;
        out_payload.distance_res  <= '0;
        out_payload.opacity       <= '0;
      end
      out_payload.last <= cmd.idx == IDX_W'(SLOTS - 1);
    end
  end

  assign sts.func     = item.func;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || out_ready;
  assign sts.count    = count;

endmodule

// ----- sv/fst_ctrl.sv -----
// controller: sequences divide, slot walk, table update and result beats
module fst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output fst_pkg::fst_cmd_t  cmd,
  input  fst_pkg::fst_sts_t  sts
);
  import fst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV,
    ST_WALK,
    ST_FINISH,
    ST_EMIT
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;
  logic             walk_last;

  assign in_ready  = state == ST_IDLE;
  assign walk_last = (CNT_W'(idx) + CNT_W'(1)) == sts.count;

  always_comb begin
    cmd     = '0;
    cmd.idx = idx;
    unique case (state)
      ST_IDLE:     cmd.load      = in_valid;
      ST_DISPATCH: cmd.div_start = sts.func != FUNC_TICK;
      ST_DIV:      ;
      ST_WALK:     cmd.walk      = CNT_W'(idx) < sts.count;
      ST_FINISH:   cmd.finish    = 1'b1;
      ST_EMIT:     cmd.emit      = sts.out_free;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_DISPATCH;
        end
        ST_DISPATCH: begin
          idx   <= '0;
          state <= (sts.func == FUNC_TICK) ? ST_WALK : ST_DIV;
        end
        ST_DIV: begin
          if (sts.div_done) state <= ST_WALK;
        end
        ST_WALK: begin
          if (!cmd.walk || walk_last) state <= ST_FINISH;
          else                        idx   <= idx + 1'b1;
        end
        ST_FINISH: begin
          idx   <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (sts.out_free) begin
            if (idx == IDX_W'(SLOTS - 1)) state <= ST_IDLE;
            else                          idx   <= idx + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_tick_skips_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (sts.func != FUNC_TICK))
    else $error("tick item waiting on divider");

  a_finish_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |=> (state == ST_EMIT && idx == '0))
    else $error("result walk does not start at slot zero");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    $rose(sts.div_done) |-> (state == ST_DIV))
    else $error("divider finished outside divide wait");

endmodule
